// ===== rtl/ceau_pkg.sv =====
// Shared types and constants for the effective address unit.
package ceau_pkg;

    localparam int unsigned MODE_W  = 4;
    localparam int unsigned ADDR_W  = 24;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDLE_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_IMM = 4'd0,
        MODE_DP  = 4'd1,
        MODE_DPX = 4'd2,
        MODE_DPY = 4'd3,
        MODE_IDP = 4'd4,
        MODE_IDX = 4'd5,
        MODE_IDY = 4'd6,
        MODE_IDL = 4'd7,
        MODE_ILY = 4'd8,
        MODE_SR  = 4'd9,
        MODE_ISY = 4'd10,
        MODE_ABS = 4'd11,
        MODE_ABX = 4'd12,
        MODE_ABY = 4'd13,
        MODE_ABL = 4'd14,
        MODE_ALX = 4'd15
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] operand;
        logic [ADDR_W-1:0] pointer;
        logic [WORD_W-1:0] direct_page;
        logic [BYTE_W-1:0] data_bank;
        logic [ADDR_W-1:0] program_address;
        logic [WORD_W-1:0] index_x;
        logic [WORD_W-1:0] index_y;
        logic [WORD_W-1:0] stack_pointer;
        logic              is_write;
        logic              index_is_8bit;
        logic              immediate_is_8bit;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] low_address;
        logic [ADDR_W-1:0] high_address;
        logic [WORD_W-1:0] pointer_address;
        logic [IDLE_W-1:0] idle_cycles;
    } rsp_t;

endpackage

// ===== rtl/ceau_if.sv =====
// Valid/ready channel interfaces for the request and result beats.
interface ceau_req_if;
    import ceau_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] operand;
    logic [ADDR_W-1:0] pointer;
    logic [WORD_W-1:0] direct_page;
    logic [BYTE_W-1:0] data_bank;
    logic [ADDR_W-1:0] program_address;
    logic [WORD_W-1:0] index_x;
    logic [WORD_W-1:0] index_y;
    logic [WORD_W-1:0] stack_pointer;
    logic              is_write;
    logic              index_is_8bit;
    logic              immediate_is_8bit;

    modport source (
        output valid, mode, operand, pointer, direct_page, data_bank, program_address,
               index_x, index_y, stack_pointer, is_write, index_is_8bit,
               immediate_is_8bit,
        input  ready
    );

    modport sink (
        input  valid, mode, operand, pointer, direct_page, data_bank, program_address,
               index_x, index_y, stack_pointer, is_write, index_is_8bit,
               immediate_is_8bit,
        output ready
    );
endinterface

interface ceau_rsp_if;
    import ceau_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] low_address;
    logic [ADDR_W-1:0] high_address;
    logic [WORD_W-1:0] pointer_address;
    logic [IDLE_W-1:0] idle_cycles;

    modport source (
        output valid, low_address, high_address, pointer_address, idle_cycles,
        input  ready
    );

    modport sink (
        input  valid, low_address, high_address, pointer_address, idle_cycles,
        output ready
    );
endinterface

// ===== rtl/ceau_addr_calc.sv =====
// Address arithmetic for all sixteen addressing modes.
module ceau_addr_calc (
    input  ceau_pkg::req_t req,
    output ceau_pkg::rsp_t rsp
);
    import ceau_pkg::*;

    logic [BYTE_W-1:0] a8;
    logic [WORD_W-1:0] a16;
    logic [WORD_W-1:0] p16;
    logic [IDLE_W-1:0] dp_idle;
    logic              use_x;
    logic [WORD_W-1:0] idx_sel;
    logic [WORD_W-1:0] dp_base;
    logic [WORD_W-1:0] dp_idx;
    logic [WORD_W-1:0] sr_base;
    logic [ADDR_W-1:0] ptr_y;
    logic [ADDR_W-1:0] abs_idx;
    logic [ADDR_W-1:0] long_idx;
    logic [WORD_W:0]   p_sum;
    logic [WORD_W:0]   a_sum;
    logic              cross_p;
    logic              cross_a;
    logic              slow_p;
    logic              slow_a;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [WORD_W-1:0] pad;
    logic [IDLE_W-1:0] idle;
    logic              wrap16;
    mode_t             mode;

    assign mode    = mode_t'(req.mode);
    assign a8      = req.operand[BYTE_W-1:0];
    assign a16     = req.operand[WORD_W-1:0];
    assign p16     = req.pointer[WORD_W-1:0];
    assign dp_idle = {1'b0, (req.direct_page[BYTE_W-1:0] != '0)};

    assign use_x   = (mode == MODE_DPX) || (mode == MODE_IDX) || (mode == MODE_ABX) ||
                     (mode == MODE_ALX);
    assign idx_sel = use_x ? req.index_x : req.index_y;

    assign dp_base  = req.direct_page + {{(WORD_W-BYTE_W){1'b0}}, a8};
    assign dp_idx   = dp_base + idx_sel;
    assign sr_base  = req.stack_pointer + {{(WORD_W-BYTE_W){1'b0}}, a8};
    assign ptr_y    = {req.data_bank, p16} + {{(ADDR_W-WORD_W){1'b0}}, req.index_y};
    assign abs_idx  = {req.data_bank, a16} + {{(ADDR_W-WORD_W){1'b0}}, idx_sel};
    // Long modes add the index to the full 24-bit base.
    assign long_idx = ((mode == MODE_IDL) || (mode == MODE_ILY)) ?
                      (req.pointer + {{(ADDR_W-WORD_W){1'b0}}, req.index_y}) :
                      (req.operand + {{(ADDR_W-WORD_W){1'b0}}, req.index_x});

    // Page cross: the high byte of base plus index differs from the base's.
    assign p_sum   = {1'b0, p16} + {1'b0, req.index_y};
    assign a_sum   = {1'b0, a16} + {1'b0, idx_sel};
    assign cross_p = p_sum[WORD_W:BYTE_W] != {1'b0, p16[WORD_W-1:BYTE_W]};
    assign cross_a = a_sum[WORD_W:BYTE_W] != {1'b0, a16[WORD_W-1:BYTE_W]};
    assign slow_p  = req.is_write || !req.index_is_8bit || cross_p;
    assign slow_a  = req.is_write || !req.index_is_8bit || cross_a;

    always_comb
    begin
        lo     = '0;
        pad    = '0;
        idle   = '0;
        wrap16 = 1'b0;
        unique case (mode)
            MODE_IMM:
            begin
                lo = req.program_address;
            end
            MODE_DP:
            begin
                lo     = {{BYTE_W{1'b0}}, dp_base};
                idle   = dp_idle;
                wrap16 = 1'b1;
            end
            MODE_DPX, MODE_DPY:
            begin
                lo     = {{BYTE_W{1'b0}}, dp_idx};
                idle   = dp_idle + 2'd1;
                wrap16 = 1'b1;
            end
            MODE_IDP:
            begin
                lo   = {req.data_bank, p16};
                pad  = dp_base;
                idle = dp_idle;
            end
            MODE_IDX:
            begin
                lo   = {req.data_bank, p16};
                pad  = dp_idx;
                idle = dp_idle + 2'd1;
            end
            MODE_IDY:
            begin
                lo   = ptr_y;
                pad  = dp_base;
                idle = dp_idle + {1'b0, slow_p};
            end
            MODE_IDL, MODE_ILY:
            begin
                lo   = (mode == MODE_ILY) ? long_idx : req.pointer;
                pad  = dp_base;
                idle = dp_idle;
            end
            MODE_SR:
            begin
                lo     = {{BYTE_W{1'b0}}, sr_base};
                idle   = 2'd1;
                wrap16 = 1'b1;
            end
            MODE_ISY:
            begin
                lo   = ptr_y;
                pad  = sr_base;
                idle = 2'd2;
            end
            MODE_ABS:
            begin
                lo = {req.data_bank, a16};
            end
            MODE_ABX, MODE_ABY:
            begin
                lo   = abs_idx;
                idle = {1'b0, slow_a};
            end
            MODE_ABL:
            begin
                lo = req.operand;
            end
            MODE_ALX:
            begin
                lo = long_idx;
            end
        endcase

        // Immediate keeps the program bank (high is zero when 8-bit); bank-0 modes wrap within 16 bits.
        if (mode == MODE_IMM)
        begin
            hi = req.immediate_is_8bit ? '0 : {lo[ADDR_W-1:WORD_W], lo[WORD_W-1:0] + 16'd1};
        end
        else if (wrap16)
        begin
            hi = {{BYTE_W{1'b0}}, lo[WORD_W-1:0] + 16'd1};
        end
        else
        begin
            hi = lo + 24'd1;
        end
    end

    assign rsp.low_address     = lo;
    assign rsp.high_address    = hi;
    assign rsp.pointer_address = pad;
    assign rsp.idle_cycles     = idle;

endmodule

// ===== rtl/cpu_effective_address_unit.sv =====
// Top level: request register, address arithmetic and result register.
//
// Usage: drive one request beat on cmd per instruction with the addressing
// mode, operand bytes, fetched pointer and the current register values.
// The matching result beat on result carries the low and high data
// addresses, the bank-0 pointer fetch address and the extra idle cycles.
//
// An accepted cmd beat is held in the request register, then passes through
// the address arithmetic into the result register. Throughput is one beat
// per cycle while the receiver takes results, set by the single pass
// through the adders between the two registers.
//
// cmd.ready stays high while the result register can drain or the request
// register is empty, so a new beat is taken while a finished result still
// waits. When the receiver stalls, both registers fill and cmd.ready drops;
// results come out in order and none is dropped.
//
// Reset clears both valid flags; no result is presented until a beat is
// accepted after reset.
module cpu_effective_address_unit (
    input logic         clk,
    input logic         rst_n,
    ceau_req_if.sink    cmd,
    ceau_rsp_if.source  result
);
    import ceau_pkg::*;

    logic  req_valid_reg;
    logic  req_valid_next;
    req_t  req_reg;
    req_t  req_next;
    logic  rsp_valid_reg;
    logic  rsp_valid_next;
    rsp_t  rsp_reg;
    rsp_t  calc_rsp;
    logic  rsp_load;
    logic  req_load;

    assign rsp_load = !rsp_valid_reg || result.ready;
    assign req_load = !req_valid_reg || rsp_load;

    assign cmd.ready = req_load;

    always_comb
    begin
        req_next.mode              = cmd.mode;
        req_next.operand           = cmd.operand;
        req_next.pointer           = cmd.pointer;
        req_next.direct_page       = cmd.direct_page;
        req_next.data_bank         = cmd.data_bank;
        req_next.program_address   = cmd.program_address;
        req_next.index_x           = cmd.index_x;
        req_next.index_y           = cmd.index_y;
        req_next.stack_pointer     = cmd.stack_pointer;
        req_next.is_write          = cmd.is_write;
        req_next.index_is_8bit     = cmd.index_is_8bit;
        req_next.immediate_is_8bit = cmd.immediate_is_8bit;
    end

    assign req_valid_next = req_load ? cmd.valid : req_valid_reg;
    assign rsp_valid_next = rsp_load ? req_valid_reg : rsp_valid_reg;

    ceau_addr_calc u_calc (
        .req (req_reg),
        .rsp (calc_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (req_load && cmd.valid)
        begin
            req_reg <= req_next;
        end
        if (rsp_load && req_valid_reg)
        begin
            rsp_reg <= calc_rsp;
        end
    end

    assign result.valid           = rsp_valid_reg;
    assign result.low_address     = rsp_reg.low_address;
    assign result.high_address    = rsp_reg.high_address;
    assign result.pointer_address = rsp_reg.pointer_address;
    assign result.idle_cycles     = rsp_reg.idle_cycles;

    // An accepted beat occupies the request register next cycle.
    a_cmd_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> req_valid_reg)
        else $error("accepted request beat not captured");

    // With both registers full and the output stalled, no beat may enter.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && rsp_valid_reg && !result.ready) |-> !cmd.ready)
        else $error("request taken while pipeline is full");

    // A pending request moves to the result side once the output drains.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && (!rsp_valid_reg || result.ready)) |=> rsp_valid_reg)
        else $error("pending request did not advance");

    // The idle count never exceeds two.
    a_idle_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.idle_cycles != 2'd3))
        else $error("idle cycle count out of range");

endmodule
